// File: rtl/rbam_pkg.sv
// ----------------------------------------------------------------------------
// rbam_pkg
// Shared types, constants and helpers for the ROM bank address mapper.
// ----------------------------------------------------------------------------
package rbam_pkg;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MAP_W    = 21;
    localparam int SIZE_W   = 3;
    localparam int BANK_W   = 8;
    localparam int PAGE_SH  = 14;   // one ROM bank spans 16 KiB

    localparam logic [BANK_W-1:0] MAX_BANKS = 8'd64;
    localparam logic [BANK_W-1:0] BANK_ONE  = 8'd1;

    // access kinds carried in s_tuser
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // rom size codes
    localparam logic [SIZE_W-1:0] SIZE_4   = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_8   = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_16  = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_32  = 3'd4;
    localparam logic [SIZE_W-1:0] SIZE_64  = 3'd5;

    // bank register update from the decode logic
    typedef struct packed {
        logic              we;
        logic [BANK_W-1:0] value;
    } bank_upd_t;

    // one decoded result
    typedef struct packed {
        logic [MAP_W-1:0] mapped_address;
        logic             accepted;
    } map_res_t;

    // bank mask for a size code, unused codes give no mask
    function automatic logic [BANK_W-1:0] bank_mask(input logic [SIZE_W-1:0] code);
        logic [BANK_W-1:0] m;
        case (code)
            SIZE_4:  m = 8'h03;
            SIZE_8:  m = 8'h07;
            SIZE_16: m = 8'h0F;
            SIZE_32: m = 8'h1F;
            SIZE_64: m = 8'h3F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/rbam_regs.sv
// ----------------------------------------------------------------------------
// rbam_regs
// Holds the rom size code and the selected ROM bank number.
// ----------------------------------------------------------------------------
module rbam_regs import rbam_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  bank_upd_t         bank_upd,
    output logic [SIZE_W-1:0] size_code,
    output logic [BANK_W-1:0] bank
);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [BANK_W-1:0] bank_reg, bank_next;

    // next values
    always_comb begin
        size_next = cfg_we ? cfg_wdata : size_reg;
        bank_next = bank_upd.we ? bank_upd.value : bank_reg;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '0;
            bank_reg <= BANK_ONE;
        end else begin
            size_reg <= size_next;
            bank_reg <= bank_next;
        end
    end

    assign size_code = size_reg;
    assign bank      = bank_reg;

endmodule

// File: rtl/rbam_map.sv
// ----------------------------------------------------------------------------
// rbam_map
// Decodes one bus access: bank select writes and ROM address translation.
// ----------------------------------------------------------------------------
module rbam_map import rbam_pkg::*; (
    input  logic              take,
    input  logic              action,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    input  logic [SIZE_W-1:0] size_code,
    input  logic [BANK_W-1:0] bank,
    output bank_upd_t         bank_upd,
    output map_res_t          res
);

    logic [BANK_W-1:0] bank_masked;
    logic [BANK_W-1:0] bank_eff;
    logic [BANK_W-1:0] bank_m1;
    logic [MAP_W-1:0]  bank_base;
    logic              in_rom;
    logic              bank_sel_hit;

    // effective bank, zero counts as one
    // the base is only used for banks up to 64, so the low bits of bank_m1 suffice
    always_comb begin
        bank_masked = bank & bank_mask(size_code);
        bank_eff    = (bank_masked == '0) ? BANK_ONE : bank_masked;
        bank_m1     = bank_eff - BANK_ONE;
        bank_base   = {bank_m1[MAP_W-PAGE_SH-1:0], {PAGE_SH{1'b0}}};
    end

    // address window decode
    assign in_rom       = (address[15] == 1'b0);
    assign bank_sel_hit = (address[15:13] == 3'b001);

    // bank register write, a written zero selects bank one
    always_comb begin
        bank_upd.we    = take && (action == ACT_WRITE) && bank_sel_hit;
        bank_upd.value = (write_data == '0) ? BANK_ONE : write_data;
    end

    // result
    always_comb begin
        res.mapped_address = '0;
        res.accepted       = 1'b0;
        if (in_rom) begin
            if (action == ACT_WRITE) begin
                res.accepted = 1'b1;
            end else if (address[14] == 1'b0) begin
                res.mapped_address = {{(MAP_W-ADDR_W){1'b0}}, address};
                res.accepted       = 1'b1;
            end else if (bank_eff <= MAX_BANKS) begin
                res.mapped_address = {{(MAP_W-ADDR_W){1'b0}}, address} + bank_base;
                res.accepted       = 1'b1;
            end
        end
    end

endmodule

// File: rtl/rbam_out_reg.sv
// ----------------------------------------------------------------------------
// rbam_out_reg
// Result register between the decode logic and the master stream side.
// ----------------------------------------------------------------------------
module rbam_out_reg import rbam_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  map_res_t in_res,
    output logic     out_valid,
    input  logic     out_ready,
    output map_res_t out_res
);

    logic     valid_reg, valid_next;
    map_res_t res_reg, res_next;

    // free when empty or when the held beat leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                res_next = in_res;
            end
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: rtl/rom_bank_address_mapper.sv
// ----------------------------------------------------------------------------
// rom_bank_address_mapper
// ROM bank controller for cartridge bus accesses, ROM banking only.
// ----------------------------------------------------------------------------
// Slave stream: one beat per bus access, s_tuser is the access kind
// (0 read, 1 write), s_tdata holds the address and the write byte.
// Master stream: one beat per access with the ROM image address in
// m_tdata and the accepted flag in m_tuser.
// A write to 0x2000-0x3FFF selects the ROM bank (zero selects bank 1),
// other writes below 0x8000 are accepted with no effect. Reads below
// 0x4000 pass through, reads at 0x4000-0x7FFF map into the selected bank.
// Accesses at 0x8000 and up, and banks above 64, are not accepted.
// cfg_wdata loads the rom size code on cfg_we; the user must load it only while
// the block is idle, the block itself does not enforce this. m_tvalid rises in the cycle after the accepted slave beat.
// Throughput: one beat per cycle while m_tready is high, set by the single result register.
// Reset: result register empty, bank 1 selected, size code 0 (no mask).
// Stall: while m_tready is low the held beat stays and s_tready drops
// once the result register is full.
// ----------------------------------------------------------------------------
module rom_bank_address_mapper import rbam_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,   // rom_size_code
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,     // [15:0] address, [23:16] write_data
    input  logic              s_tuser,     // [0] action
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,     // [20:0] mapped_address, [23:21] zero
    output logic              m_tuser      // [0] accepted
);

    logic              take;
    logic [SIZE_W-1:0] size_code;
    logic [BANK_W-1:0] bank;
    bank_upd_t         bank_upd;
    map_res_t          res_comb;
    map_res_t          res_out;

    assign take = s_tvalid && s_tready;

    // configuration and bank state
    rbam_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bank_upd  (bank_upd),
        .size_code (size_code),
        .bank      (bank)
    );

    // access decode and address translation
    rbam_map u_map (
        .take       (take),
        .action     (s_tuser),
        .address    (s_tdata[15:0]),
        .write_data (s_tdata[23:16]),
        .size_code  (size_code),
        .bank       (bank),
        .bank_upd   (bank_upd),
        .res        (res_comb)
    );

    // result register
    rbam_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (res_comb),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res_out)
    );

    assign m_tdata = {{(24-MAP_W){1'b0}}, res_out.mapped_address};
    assign m_tuser = res_out.accepted;

endmodule

// File: rtl/rbam_checker.sv
// ----------------------------------------------------------------------------
// rbam_checker
// Port level checks for the ROM bank address mapper.
// ----------------------------------------------------------------------------
module rbam_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // a held result beat does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // accesses at 0x8000 and up fail with a zero address
    a_high_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[15] |=> m_tvalid && !m_tuser && (m_tdata == 24'd0))
        else $error("high access not rejected");

    // reads in the fixed window pass the address through
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && (s_tdata[15:14] == 2'b00)
        |=> m_tvalid && m_tuser && (m_tdata[15:0] == $past(s_tdata[15:0]))
            && (m_tdata[23:16] == 8'd0))
        else $error("fixed window read not passed through");

endmodule

bind rom_bank_address_mapper rbam_checker u_rbam_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
